### design/bau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bau_pkg: shared types and constants of the BCD adjust unit
// Command codes, item structs and the pipeline record passed between stages.
// ----------------------------------------------------------------------------
package bau_pkg;

    typedef enum logic [2:0] {
        CMD_DAA = 3'd0,
        CMD_DAS = 3'd1,
        CMD_AAA = 3'd2,
        CMD_AAS = 3'd3,
        CMD_AAM = 3'd4,
        CMD_AAD = 3'd5
    } cmd_t;

    // How the last stage forms S, Z and P.
    typedef enum logic [1:0] {
        SZP_KEEP = 2'd0,  // carry the flags through as they are
        SZP_BYTE = 2'd1,  // follow the new AL
        SZP_WORD = 2'd2   // S and Z follow AH:AL, P follows AL
    } szp_mode_t;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned NibbleW = 4;

    localparam logic [ByteW-1:0]   AdjLo  = 8'h06;
    localparam logic [ByteW-1:0]   AdjHi  = 8'h60;
    localparam logic [ByteW-1:0]   BcdMax = 8'h99;
    localparam logic [NibbleW-1:0] DigMax = 4'h9;

    typedef struct packed {
        cmd_t             cmd;
        logic [ByteW-1:0] al_in;
        logic [ByteW-1:0] ah_in;
        logic [ByteW-1:0] imm;
        logic             cy_in;
        logic             ac_in;
        logic             v_in;
        logic             s_in;
        logic             z_in;
        logic             p_in;
    } bau_op_t;

    typedef struct packed {
        logic [ByteW-1:0] al_out;
        logic [ByteW-1:0] ah_out;
        logic             cy_out;
        logic             ac_out;
        logic             v_out;
        logic             s_out;
        logic             z_out;
        logic             p_out;
        logic             divide_error;
    } bau_res_t;

    // Record between the adjust stage and the flag stage.
    typedef struct packed {
        logic [ByteW-1:0] al;
        logic [ByteW-1:0] ah;
        logic             cy;
        logic             ac;
        logic             v;
        logic             s;
        logic             z;
        logic             p;
        logic             derr;
        szp_mode_t        szp;
    } bau_mid_t;

endpackage

### design/bcd_adjust_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_adjust_unit: decimal and ASCII adjust unit (DAA DAS AAA AAS AAM AAD)
// Three-stage pipeline returning new AL, AH and flags for each command item.
// ----------------------------------------------------------------------------
// Usage: drive start with a command item on operand; busy is always low, so
// an item is taken on every cycle start is high. Each item produces exactly
// one result on the result port, marked by done for one cycle, once the item
// has passed every stage register of the pipeline (one item per cycle sustained).
// The AAM divider takes eight restoring steps, split over the first two
// stages, and a final stage forms S, Z and P. The receiver
// cannot stall, so results must be captured on the cycle done is high.
// ----------------------------------------------------------------------------
module bcd_adjust_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bau_pkg::bau_op_t  operand,
    output logic              done,
    output bau_pkg::bau_res_t result
);
    import bau_pkg::*;

    // Stage 1: first half of the AAM divide, AAD product
    logic [ByteW-1:0]   rem_a;
    logic [NibbleW-1:0] quo_a;

    logic               v1_reg;
    bau_op_t            op1_reg;
    logic [ByteW-1:0]   rem1_reg;
    logic [NibbleW-1:0] quo1_reg;
    logic [ByteW-1:0]   prod1_reg;
    logic [2*ByteW-1:0] prod_full;

    // Stage 2: second half of the divide and per-command adjust
    logic [ByteW-1:0]   rem_b;
    logic [NibbleW-1:0] quo_b;
    bau_mid_t           mid_next;
    logic               v2_reg;
    bau_mid_t           mid2_reg;

    // Stage 3: S, Z and P, output register
    bau_res_t           res_next;
    logic               v3_reg;
    bau_res_t           res3_reg;

    // The pipeline never holds back, so it is always ready.
    assign busy = 1'b0;

    bau_div_half u_div_hi (
        .rem_in  ('0),
        .bits_in (operand.al_in[ByteW-1:NibbleW]),
        .divisor (operand.imm),
        .rem_out (rem_a),
        .quo_out (quo_a)
    );

    // Only the low byte of AH times imm matters for AAD.
    assign prod_full = operand.ah_in * operand.imm;

    // Valid bits: advance one stage per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op1_reg   <= operand;
        rem1_reg  <= rem_a;
        quo1_reg  <= quo_a;
        prod1_reg <= prod_full[ByteW-1:0];
        mid2_reg  <= mid_next;
        res3_reg  <= res_next;
    end

    bau_div_half u_div_lo (
        .rem_in  (rem1_reg),
        .bits_in (op1_reg.al_in[NibbleW-1:0]),
        .divisor (op1_reg.imm),
        .rem_out (rem_b),
        .quo_out (quo_b)
    );

    bau_adjust u_adjust (
        .op   (op1_reg),
        .prod (prod1_reg),
        .quo  ({quo1_reg, quo_b}),
        .rem  (rem_b),
        .mid  (mid_next)
    );

    // Form S, Z and P from the new bytes where the command asks for it.
    always_comb
    begin
        res_next.al_out       = mid2_reg.al;
        res_next.ah_out       = mid2_reg.ah;
        res_next.cy_out       = mid2_reg.cy;
        res_next.ac_out       = mid2_reg.ac;
        res_next.v_out        = mid2_reg.v;
        res_next.s_out        = mid2_reg.s;
        res_next.z_out        = mid2_reg.z;
        res_next.p_out        = mid2_reg.p;
        res_next.divide_error = mid2_reg.derr;
        case (mid2_reg.szp)
            SZP_BYTE:
            begin
                res_next.s_out = mid2_reg.al[ByteW-1];
                res_next.z_out = (mid2_reg.al == '0);
                res_next.p_out = ~^mid2_reg.al;
            end
            SZP_WORD:
            begin
                res_next.s_out = mid2_reg.ah[ByteW-1];
                res_next.z_out = ({mid2_reg.ah, mid2_reg.al} == '0);
                res_next.p_out = ~^mid2_reg.al;
            end
            default:
            begin
                res_next.s_out = mid2_reg.s;
            end
        endcase
    end

    assign done   = v3_reg;
    assign result = res3_reg;

endmodule

### design/bau_div_half.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bau_div_half: four restoring division steps
// Shift in four dividend bits, develop four quotient bits.
// ----------------------------------------------------------------------------
module bau_div_half (
    input  logic [bau_pkg::ByteW-1:0]   rem_in,
    input  logic [bau_pkg::NibbleW-1:0] bits_in,
    input  logic [bau_pkg::ByteW-1:0]   divisor,
    output logic [bau_pkg::ByteW-1:0]   rem_out,
    output logic [bau_pkg::NibbleW-1:0] quo_out
);
    import bau_pkg::*;

    logic [ByteW:0]   trial;
    logic [ByteW-1:0] rem;

    always_comb
    begin
        rem     = rem_in;
        trial   = '0;
        quo_out = '0;
        for (int i = NibbleW - 1; i >= 0; i--)
        begin
            trial = {rem, bits_in[i]};
            if (trial >= {1'b0, divisor})
            begin
                trial      = trial - {1'b0, divisor};
                quo_out[i] = 1'b1;
            end
            rem = trial[ByteW-1:0];
        end
        rem_out = rem;
    end

endmodule

### design/bau_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bau_adjust: per-command result bytes and carry-type flags
// Form AL, AH, CY, AC, V and pick how S, Z and P are produced.
// ----------------------------------------------------------------------------
module bau_adjust (
    input  bau_pkg::bau_op_t              op,
    input  logic [bau_pkg::ByteW-1:0]     prod,
    input  logic [bau_pkg::ByteW-1:0]     quo,
    input  logic [bau_pkg::ByteW-1:0]     rem,
    output bau_pkg::bau_mid_t             mid
);
    import bau_pkg::*;

    logic             neg;
    logic             lo_fix;
    logic             hi_fix;
    logic [ByteW-1:0] cur1;
    logic [ByteW-1:0] cur2;
    logic             ovf1;
    logic             ovf2;
    logic [ByteW-1:0] aa_al;
    logic [ByteW-1:0] aa_ah;
    logic [ByteW:0]   sum;

    always_comb
    begin
        neg    = (op.cmd == CMD_DAS) || (op.cmd == CMD_AAS);
        lo_fix = op.ac_in || (op.al_in[NibbleW-1:0] > DigMax);
        hi_fix = op.cy_in || (op.al_in > BcdMax);

        // DAA / DAS: low digit fix, then high digit fix on the result
        cur1 = op.al_in;
        ovf1 = 1'b0;
        if (lo_fix)
        begin
            cur1 = neg ? op.al_in - AdjLo : op.al_in + AdjLo;
            ovf1 = neg ? (op.al_in[7] & (op.al_in[7] ^ cur1[7]))
                       : (cur1[7] & ~op.al_in[7]);
        end
        cur2 = cur1;
        ovf2 = 1'b0;
        if (hi_fix)
        begin
            cur2 = neg ? cur1 - AdjHi : cur1 + AdjHi;
            ovf2 = neg ? (cur1[7] & (cur1[7] ^ cur2[7]))
                       : (cur2[7] & ~cur1[7]);
        end

        // AAA / AAS
        aa_al = lo_fix ? (neg ? op.al_in - AdjLo : op.al_in + AdjLo) : op.al_in;
        aa_ah = lo_fix ? (neg ? op.ah_in - 8'd1 : op.ah_in + 8'd1) : op.ah_in;

        // AAD
        sum = {1'b0, op.al_in} + {1'b0, prod};

        mid.al   = op.al_in;
        mid.ah   = op.ah_in;
        mid.cy   = op.cy_in;
        mid.ac   = op.ac_in;
        mid.v    = op.v_in;
        mid.s    = op.s_in;
        mid.z    = op.z_in;
        mid.p    = op.p_in;
        mid.derr = 1'b0;
        mid.szp  = SZP_KEEP;

        case (op.cmd)
            CMD_DAA, CMD_DAS:
            begin
                mid.al  = cur2;
                mid.ac  = lo_fix;
                mid.cy  = hi_fix;
                mid.v   = ovf1 | ovf2;
                mid.szp = SZP_BYTE;
            end
            CMD_AAA, CMD_AAS:
            begin
                mid.al = {{(ByteW-NibbleW){1'b0}}, aa_al[NibbleW-1:0]};
                mid.ah = aa_ah;
                mid.ac = lo_fix;
                mid.cy = lo_fix;
                mid.s  = ~lo_fix;
                mid.z  = lo_fix;
                mid.v  = 1'b0;
                mid.p  = 1'b1;
            end
            CMD_AAM:
            begin
                if (op.imm == '0)
                begin
                    mid.derr = 1'b1;
                end
                else
                begin
                    mid.al  = rem;
                    mid.ah  = quo;
                    mid.szp = SZP_WORD;
                end
            end
            CMD_AAD:
            begin
                mid.al  = sum[ByteW-1:0];
                mid.ah  = '0;
                mid.cy  = sum[ByteW];
                mid.ac  = op.al_in[4] ^ prod[4] ^ sum[4];
                mid.v   = (sum[7] ^ op.al_in[7]) & (sum[7] ^ prod[7]);
                mid.szp = SZP_BYTE;
            end
            default:
            begin
                mid.szp = SZP_KEEP;
            end
        endcase
    end

endmodule
